// ===== hw/rtl/grid_astar_path_search_assert.svh =====
// Assertion macros for the grid path search block.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef GRID_ASTAR_PATH_SEARCH_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_ASSERT_SVH

// Check a property outside reset.
`define GASP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every edge, reset included.
`define GASP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/gasp_pkg.sv =====
// Shared constants, codes, types and helper functions for the grid path search.
// No dependencies.
package gasp_pkg;

    localparam int GRID_W_DEF = 32;
    localparam int GRID_H_DEF = 32;
    localparam int IN_CW      = 5;    // width of coordinate fields on the bus

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    localparam logic [1:0] ST_NEW    = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    typedef struct packed {
        logic busy;
        logic done;
    } scan_rsp_t;

    // Fibonacci LFSR, taps 16,14,13,11, shifting right.
    function automatic logic [15:0] lfsr_step(input logic [15:0] l);
        logic fb;
        fb = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {fb, l[15:1]};
    endfunction

    // Map two random bits to left, up, down, right.
    function automatic logic [1:0] rand_dir(input logic [1:0] r);
        logic [1:0] d;
        case (r)
            2'd0:    d = DIR_LEFT;
            2'd1:    d = DIR_UP;
            2'd2:    d = DIR_DOWN;
            default: d = DIR_RIGHT;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/gasp_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module gasp_ram #(
    parameter int W     = 2,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] ram_reg [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/gasp_min_scan.sv =====
// Minimum search over the open list: walks from the front entry down to entry 0,
// one read per cycle, through a single shared comparator. Uses gasp_pkg.
module gasp_min_scan #(
    parameter int AW = 10,
    parameter int FW = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [AW-1:0]       last_idx,
    output logic [AW-1:0]       rd_addr,
    input  logic [FW-1:0]       rd_f,
    output gasp_pkg::scan_rsp_t rsp,
    output logic [AW-1:0]       best_idx
);

    logic          issue_reg, issue_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          cmp_reg, cmp_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          first_reg, first_next;
    logic [FW-1:0] best_f_reg, best_f_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic          done_reg, done_next;

    always_comb begin
        issue_next    = issue_reg;
        idx_next      = idx_reg;
        first_next    = first_reg;
        best_f_next   = best_f_reg;
        best_idx_next = best_idx_reg;
        cmp_next      = issue_reg;
        cmp_idx_next  = idx_reg;
        done_next     = cmp_reg && (cmp_idx_reg == '0);

        // strict less-than keeps the first minimum seen from the front
        if (cmp_reg) begin
            if (first_reg || (rd_f < best_f_reg)) begin
                best_f_next   = rd_f;
                best_idx_next = cmp_idx_reg;
            end
            first_next = 1'b0;
        end

        if (start) begin
            issue_next = 1'b1;
            idx_next   = last_idx;
            first_next = 1'b1;
        end else if (issue_reg) begin
            if (idx_reg == '0) begin
                issue_next = 1'b0;
            end else begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            cmp_reg   <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            issue_reg <= issue_next;
            cmp_reg   <= cmp_next;
            done_reg  <= done_next;
            first_reg <= first_next;
        end
        idx_reg      <= idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_f_reg   <= best_f_next;
        best_idx_reg <= best_idx_next;
    end

    assign rd_addr  = idx_reg;
    assign best_idx = best_idx_reg;
    assign rsp.busy = issue_reg | cmp_reg;
    assign rsp.done = done_reg;

endmodule

// ===== hw/rtl/grid_astar_path_search.sv =====
// Grid A* path search with a move stack. After reset the block clears the obstacle
// map before it raises s_axis_tready. Each beat is one command: op 0 writes one
// obstacle cell, op 2 pops the next move (a random move when the stack is empty) and
// op 1 runs a full search. A search first sweeps the cell status memory, then for
// every expanded cell scans the open list once (one shared comparator), closes the
// gap left by the taken entry and tries four neighbours; a found path is traced back
// onto the move stack. The open list memory port and the comparator set the search
// time. One command is handled at a time; s_axis_tready is high only while the block
// is idle, and a result waits in the output register until taken. Uses gasp_pkg,
// gasp_ram, gasp_min_scan and the assertion header.
module grid_astar_path_search #(
    parameter int GRID_W = gasp_pkg::GRID_W_DEF,
    parameter int GRID_H = gasp_pkg::GRID_H_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // cell_x[4:0] cell_y[9:5] blocked[10]
                                        // goal_x[15:11] goal_y[20:16], zero above
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // found[0] move_dir[2:1] from_path[3]
                                        // path_length[14:4], zero above
);

    `include "grid_astar_path_search_assert.svh"

    localparam int CELLS = GRID_W * GRID_H;
    localparam int CW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int XW    = $clog2(GRID_W);
    localparam int YW    = $clog2(GRID_H);
    localparam int MW0   = (XW > YW) ? XW : YW;
    localparam int MW1   = (MW0 > gasp_pkg::IN_CW) ? MW0 : gasp_pkg::IN_CW;
    localparam int PW    = MW1 + 1;                        // working coordinate width
    localparam int GW    = CNTW;
    localparam int FW    = ((CNTW > PW + 1) ? CNTW : PW + 1) + 1;
    localparam int EW    = GW + FW + YW + XW;              // open list entry

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_SWEEP     = 4'd2;
    localparam logic [3:0] S_INIT      = 4'd3;
    localparam logic [3:0] S_SCAN_GO   = 4'd4;
    localparam logic [3:0] S_SCAN_WAIT = 4'd5;
    localparam logic [3:0] S_TAKE      = 4'd6;
    localparam logic [3:0] S_SH_RD     = 4'd7;
    localparam logic [3:0] S_SH_WR     = 4'd8;
    localparam logic [3:0] S_NBR       = 4'd9;
    localparam logic [3:0] S_NCHK      = 4'd10;
    localparam logic [3:0] S_TR_RD     = 4'd11;
    localparam logic [3:0] S_TR_WR     = 4'd12;
    localparam logic [3:0] S_POP       = 4'd13;
    localparam logic [3:0] S_OUT       = 4'd14;

    function automatic logic [CW-1:0] cell_idx(input logic [PW-1:0] x, input logic [PW-1:0] y);
        return CW'(32'(y) * GRID_W + 32'(x));
    endfunction

    function automatic logic [PW:0] manh(input logic [PW-1:0] ax, input logic [PW-1:0] ay,
                                         input logic [PW-1:0] bx, input logic [PW-1:0] by);
        logic [PW-1:0] dx;
        logic [PW-1:0] dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return {1'b0, dx} + {1'b0, dy};
    endfunction

    // input beat fields
    logic [1:0]    in_op;
    logic [PW-1:0] in_x, in_y, in_gx, in_gy;
    logic          in_blk;

    assign in_op  = s_axis_tuser;
    assign in_x   = PW'(s_axis_tdata[4:0]);
    assign in_y   = PW'(s_axis_tdata[9:5]);
    assign in_blk = s_axis_tdata[10];
    assign in_gx  = PW'(s_axis_tdata[15:11]);
    assign in_gy  = PW'(s_axis_tdata[20:16]);

    // sequencer state
    logic [3:0]      state_reg, state_next;
    logic [CW-1:0]   clr_reg, clr_next;
    logic [PW-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic [PW-1:0]   gx_reg, gx_next, gy_reg, gy_next;
    logic [PW-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [PW-1:0]   nx_reg, nx_next, ny_reg, ny_next;
    logic [GW-1:0]   cg_reg, cg_next;
    logic [1:0]      dir_reg, dir_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [CNTW-1:0] open_cnt_reg, open_cnt_next;
    logic [CNTW-1:0] path_cnt_reg, path_cnt_next;
    logic [CNTW-1:0] steps_reg, steps_next;
    logic [15:0]     lfsr_reg, lfsr_next;
    logic            found_reg, found_next;
    logic [1:0]      mdir_reg, mdir_next;
    logic            fp_reg, fp_next;
    logic            m_valid_reg, m_valid_next;
    logic [15:0]     m_data_reg, m_data_next;

    // memory ports
    logic          obst_we, obst_wd, obst_rd;
    logic [CW-1:0] obst_wa, obst_ra;
    logic          stat_we;
    logic [1:0]    stat_wd, stat_rd;
    logic [CW-1:0] stat_wa, stat_ra;
    logic          arr_we;
    logic [1:0]    arr_wd, arr_rd;
    logic [CW-1:0] arr_wa, arr_ra;
    logic          open_we;
    logic [EW-1:0] open_wd, open_rd;
    logic [CW-1:0] open_wa, open_ra;
    logic          stk_we;
    logic [1:0]    stk_wd, stk_rd;
    logic [CW-1:0] stk_wa, stk_ra;

    // scanner
    logic                scan_start;
    logic [CW-1:0]       scan_addr, scan_best;
    gasp_pkg::scan_rsp_t scan_rsp;

    // open list entry fields as read back
    logic [XW-1:0] ent_x;
    logic [YW-1:0] ent_y;
    logic [FW-1:0] ent_f;
    logic [GW-1:0] ent_g;

    assign ent_x = open_rd[XW-1:0];
    assign ent_y = open_rd[XW +: YW];
    assign ent_f = open_rd[XW + YW +: FW];
    assign ent_g = open_rd[XW + YW + FW +: GW];

    // neighbour of the current cell in direction dir_reg
    logic          nb_ok;
    logic [PW-1:0] nb_x, nb_y;
    logic [GW-1:0] g_new;
    logic [PW-1:0] tr_x, tr_y;

    always_comb begin
        nb_x  = cx_reg;
        nb_y  = cy_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            gasp_pkg::DIR_LEFT: begin
                nb_x  = cx_reg - 1'b1;
                nb_ok = (cx_reg != '0);
            end
            gasp_pkg::DIR_RIGHT: begin
                nb_x  = cx_reg + 1'b1;
                nb_ok = (nb_x < PW'(GRID_W));
            end
            gasp_pkg::DIR_UP: begin
                nb_y  = cy_reg - 1'b1;
                nb_ok = (cy_reg != '0);
            end
            default: begin
                nb_y  = cy_reg + 1'b1;
                nb_ok = (nb_y < PW'(GRID_H));
            end
        endcase
    end

    assign g_new = cg_reg + 1'b1;

    // back-trace moves against the arrival direction
    always_comb begin
        tr_x = cx_reg;
        tr_y = cy_reg;
        case (arr_rd)
            gasp_pkg::DIR_LEFT:  tr_x = cx_reg + 1'b1;
            gasp_pkg::DIR_RIGHT: tr_x = cx_reg - 1'b1;
            gasp_pkg::DIR_UP:    tr_y = cy_reg + 1'b1;
            default:             tr_y = cy_reg - 1'b1;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        gx_next       = gx_reg;
        gy_next       = gy_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        nx_next       = nx_reg;
        ny_next       = ny_reg;
        cg_next       = cg_reg;
        dir_next      = dir_reg;
        j_next        = j_reg;
        open_cnt_next = open_cnt_reg;
        path_cnt_next = path_cnt_reg;
        steps_next    = steps_reg;
        lfsr_next     = lfsr_reg;
        found_next    = found_reg;
        mdir_next     = mdir_reg;
        fp_next       = fp_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        obst_we = 1'b0;  obst_wa = '0;  obst_wd = 1'b0;  obst_ra = '0;
        stat_we = 1'b0;  stat_wa = '0;  stat_wd = gasp_pkg::ST_NEW;  stat_ra = '0;
        arr_we  = 1'b0;  arr_wa  = '0;  arr_wd  = dir_reg;  arr_ra  = '0;
        open_we = 1'b0;  open_wa = '0;  open_wd = '0;  open_ra = scan_addr;
        stk_we  = 1'b0;  stk_wa  = '0;  stk_wd  = arr_rd;  stk_ra  = '0;
        scan_start = 1'b0;

        // drop the result once taken
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                // free every obstacle cell and mark it new
                obst_we = 1'b1;
                obst_wa = clr_reg;
                stat_we = 1'b1;
                stat_wa = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    found_next = 1'b0;
                    mdir_next  = gasp_pkg::DIR_LEFT;
                    fp_next    = 1'b0;
                    state_next = S_OUT;
                    unique case (in_op)
                        gasp_pkg::OP_WRITE: begin
                            if ((in_x < PW'(GRID_W)) && (in_y < PW'(GRID_H))) begin
                                obst_we = 1'b1;
                                obst_wa = cell_idx(in_x, in_y);
                                obst_wd = in_blk;
                            end
                        end
                        gasp_pkg::OP_SEARCH: begin
                            sx_next       = in_x;
                            sy_next       = in_y;
                            gx_next       = in_gx;
                            gy_next       = in_gy;
                            open_cnt_next = '0;
                            path_cnt_next = '0;
                            clr_next      = '0;
                            state_next    = S_SWEEP;
                        end
                        gasp_pkg::OP_POP: begin
                            if (path_cnt_reg != '0) begin
                                stk_ra     = CW'(path_cnt_reg - 1'b1);
                                state_next = S_POP;
                            end else begin
                                lfsr_next = gasp_pkg::lfsr_step(lfsr_reg);
                                mdir_next = gasp_pkg::rand_dir(lfsr_next[1:0]);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                stat_we  = 1'b1;
                stat_wa  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(CELLS - 1)) begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                if ((sx_reg >= PW'(GRID_W)) || (sy_reg >= PW'(GRID_H)) ||
                    ((sx_reg == gx_reg) && (sy_reg == gy_reg))) begin
                    state_next = S_OUT;
                end else begin
                    // push the start cell with G of zero
                    open_we = 1'b1;
                    open_wa = '0;
                    open_wd = {GW'(0), FW'(manh(sx_reg, sy_reg, gx_reg, gy_reg)),
                               YW'(sy_reg), XW'(sx_reg)};
                    stat_we = 1'b1;
                    stat_wa = cell_idx(sx_reg, sy_reg);
                    stat_wd = gasp_pkg::ST_OPEN;
                    open_cnt_next = CNTW'(1);
                    state_next    = S_SCAN_GO;
                end
            end
            S_SCAN_GO: begin
                if (open_cnt_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    scan_start = 1'b1;
                    state_next = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: begin
                if (scan_rsp.done) begin
                    open_ra    = scan_best;
                    j_next     = scan_best;
                    state_next = S_TAKE;
                end
            end
            S_TAKE: begin
                cx_next = PW'(ent_x);
                cy_next = PW'(ent_y);
                cg_next = ent_g;
                stat_we = 1'b1;
                stat_wa = cell_idx(PW'(ent_x), PW'(ent_y));
                stat_wd = gasp_pkg::ST_CLOSED;
                state_next = S_SH_RD;
            end
            S_SH_RD: begin
                // close the gap left by the taken entry
                if (({1'b0, j_reg} + 1'b1) < ({1'b0, open_cnt_reg})) begin
                    open_ra    = j_reg + 1'b1;
                    state_next = S_SH_WR;
                end else begin
                    open_cnt_next = open_cnt_reg - 1'b1;
                    dir_next      = gasp_pkg::DIR_LEFT;
                    state_next    = S_NBR;
                end
            end
            S_SH_WR: begin
                open_we    = 1'b1;
                open_wa    = j_reg;
                open_wd    = open_rd;
                j_next     = j_reg + 1'b1;
                state_next = S_SH_RD;
            end
            S_NBR: begin
                if (nb_ok) begin
                    nx_next    = nb_x;
                    ny_next    = nb_y;
                    obst_ra    = cell_idx(nb_x, nb_y);
                    stat_ra    = cell_idx(nb_x, nb_y);
                    state_next = S_NCHK;
                end else if (dir_reg == gasp_pkg::DIR_DOWN) begin
                    state_next = S_SCAN_GO;
                end else begin
                    dir_next = dir_reg + 1'b1;
                end
            end
            S_NCHK: begin
                if ((stat_rd == gasp_pkg::ST_NEW) && !obst_rd &&
                    (nx_reg == gx_reg) && (ny_reg == gy_reg)) begin
                    found_next = 1'b1;
                    steps_next = '0;
                    state_next = S_TR_RD;
                end else begin
                    if ((stat_rd == gasp_pkg::ST_NEW) && !obst_rd) begin
                        arr_we  = 1'b1;
                        arr_wa  = cell_idx(nx_reg, ny_reg);
                        stat_we = 1'b1;
                        stat_wa = cell_idx(nx_reg, ny_reg);
                        stat_wd = gasp_pkg::ST_OPEN;
                        open_we = 1'b1;
                        open_wa = CW'(open_cnt_reg);
                        open_wd = {g_new, FW'(g_new) + FW'(manh(nx_reg, ny_reg, gx_reg, gy_reg)),
                                   YW'(ny_reg), XW'(nx_reg)};
                        open_cnt_next = open_cnt_reg + 1'b1;
                    end
                    if (dir_reg == gasp_pkg::DIR_DOWN) begin
                        state_next = S_SCAN_GO;
                    end else begin
                        dir_next   = dir_reg + 1'b1;
                        state_next = S_NBR;
                    end
                end
            end
            S_TR_RD: begin
                if (((cx_reg == sx_reg) && (cy_reg == sy_reg)) ||
                    (steps_reg == CNTW'(CELLS))) begin
                    state_next = S_OUT;
                end else begin
                    arr_ra     = cell_idx(cx_reg, cy_reg);
                    state_next = S_TR_WR;
                end
            end
            S_TR_WR: begin
                stk_we        = 1'b1;
                stk_wa        = CW'(path_cnt_reg);
                path_cnt_next = path_cnt_reg + 1'b1;
                cx_next       = tr_x;
                cy_next       = tr_y;
                if ((tr_x >= PW'(GRID_W)) || (tr_y >= PW'(GRID_H))) begin
                    state_next = S_OUT;
                end else begin
                    steps_next = steps_reg + 1'b1;
                    state_next = S_TR_RD;
                end
            end
            S_POP: begin
                mdir_next     = stk_rd;
                fp_next       = 1'b1;
                path_cnt_next = path_cnt_reg - 1'b1;
                state_next    = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, 11'(path_cnt_reg), fp_reg, mdir_reg, found_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            open_cnt_reg <= '0;
            path_cnt_reg <= '0;
            lfsr_reg     <= gasp_pkg::LFSR_SEED;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            open_cnt_reg <= open_cnt_next;
            path_cnt_reg <= path_cnt_next;
            lfsr_reg     <= lfsr_next;
            m_valid_reg  <= m_valid_next;
        end
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        gx_reg     <= gx_next;
        gy_reg     <= gy_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        cg_reg     <= cg_next;
        dir_reg    <= dir_next;
        j_reg      <= j_next;
        steps_reg  <= steps_next;
        found_reg  <= found_next;
        mdir_reg   <= mdir_next;
        fp_reg     <= fp_next;
        m_data_reg <= m_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    gasp_ram #(.W(1), .DEPTH(CELLS), .AW(CW)) u_obst_ram (
        .aclk(aclk), .we(obst_we), .waddr(obst_wa), .wdata(obst_wd),
        .raddr(obst_ra), .rdata(obst_rd)
    );

    gasp_ram #(.W(2), .DEPTH(CELLS), .AW(CW)) u_stat_ram (
        .aclk(aclk), .we(stat_we), .waddr(stat_wa), .wdata(stat_wd),
        .raddr(stat_ra), .rdata(stat_rd)
    );

    gasp_ram #(.W(2), .DEPTH(CELLS), .AW(CW)) u_arr_ram (
        .aclk(aclk), .we(arr_we), .waddr(arr_wa), .wdata(arr_wd),
        .raddr(arr_ra), .rdata(arr_rd)
    );

    gasp_ram #(.W(EW), .DEPTH(CELLS), .AW(CW)) u_open_ram (
        .aclk(aclk), .we(open_we), .waddr(open_wa), .wdata(open_wd),
        .raddr(open_ra), .rdata(open_rd)
    );

    gasp_ram #(.W(2), .DEPTH(CELLS), .AW(CW)) u_stack_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
        .raddr(stk_ra), .rdata(stk_rd)
    );

    gasp_min_scan #(.AW(CW), .FW(FW)) u_min_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_start),
        .last_idx (CW'(open_cnt_reg - 1'b1)),
        .rd_addr  (scan_addr),
        .rd_f     (ent_f),
        .rsp      (scan_rsp),
        .best_idx (scan_best)
    );

    `GASP_ASSERT(a_open_bound, (open_cnt_reg <= CNTW'(CELLS)), "open list overflow")
    `GASP_ASSERT(a_path_bound, (path_cnt_reg <= CNTW'(CELLS)), "path stack overflow")
    `GASP_ASSERT(a_scan_owner, (scan_rsp.busy |-> (state_reg == S_SCAN_WAIT)), "scan outside search")
    `GASP_ASSERT(a_one_cmd, (s_axis_tvalid && s_axis_tready |=> !s_axis_tready), "second beat taken")
    `GASP_ASSERT_ALWAYS(a_rst_busy, (!aresetn |=> !s_axis_tready), "ready during clear")

endmodule

// ===== sim/tb.sv =====
// Testbench for grid_astar_path_search: drives command beats, predicts every
// result with a behavioral A* model and compares each result beat field by field.
// Depends on gasp_pkg and the grid_astar_path_search RTL.
`timescale 1ns / 1ps

module tb;

    localparam int W = gasp_pkg::GRID_W_DEF;
    localparam int H = gasp_pkg::GRID_H_DEF;
    localparam int N = W * H;
    localparam longint LIMIT = 60_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // fields from the lowest bit up: found, dir, fp, plen
    typedef struct packed {
        logic [10:0] plen;
        logic        fp;
        logic [1:0]  dir;
        logic        found;
    } move_rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    grid_astar_path_search u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 aclk = ~aclk;

    // Shadow copy of the block's grid, search memories and move stack
    bit          blk_map [N];
    logic [1:0]  status  [N];
    int          open_q  [N];   // index 0 = back, open_n-1 = front
    int          open_n;
    int          g_cost  [N];
    int          f_cost  [N];
    logic [1:0]  came_dir[N];
    logic [1:0]  moves   [N];
    int          move_n;
    logic [15:0] lfsr;

    move_rsp_t   pending[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_start = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_left = 0;
    longint      cycles = 0;

    function automatic int absd(int a, int b);
        return a > b ? a - b : b - a;
    endfunction

    // Stack the arrival directions from the expanding cell back to the start.
    function automatic void stack_path(int cur, int sx, int sy);
        int cx, cy, steps;
        logic [1:0] d;
        cx = cur % W;
        cy = cur / W;
        steps = 0;
        while (!(cx == sx && cy == sy) && steps < N) begin
            d = came_dir[cy * W + cx];
            moves[move_n] = d;
            move_n++;
            case (d)
                gasp_pkg::DIR_LEFT:  cx++;
                gasp_pkg::DIR_RIGHT: cx--;
                gasp_pkg::DIR_UP:    cy++;
                default:             cy--;
            endcase
            if (cx < 0 || cx >= W || cy < 0 || cy >= H) break;
            steps++;
        end
    endfunction

    function automatic bit astar(int sx, int sy, int gx, int gy);
        int s, k, cur, cx, cy, nx, ny, n, best;
        for (int i = 0; i < N; i++) status[i] = gasp_pkg::ST_NEW;
        open_n = 0;
        move_n = 0;
        if (sx == gx && sy == gy) return 1'b0;
        s = sy * W + sx;
        g_cost[s] = 0;
        f_cost[s] = absd(sx, gx) + absd(sy, gy);
        status[s] = gasp_pkg::ST_OPEN;
        open_q[open_n++] = s;
        while (open_n > 0) begin
            // first minimum seen from the front of the list wins
            best = open_n - 1;
            for (int i = open_n - 1; i > 0; i--)
                if (f_cost[open_q[i-1]] < f_cost[open_q[best]]) best = i - 1;
            k = best;
            cur = open_q[k];
            cx = cur % W;
            cy = cur / W;
            for (int i = k; i < open_n - 1; i++) open_q[i] = open_q[i+1];
            open_n--;
            status[cur] = gasp_pkg::ST_CLOSED;
            for (int d = 0; d < 4; d++) begin
                nx = cx + (d == 0 ? -1 : d == 1 ? 1 : 0);
                ny = cy + (d == 2 ? -1 : d == 3 ? 1 : 0);
                if (nx < 0 || ny < 0 || nx >= W || ny >= H) continue;
                n = ny * W + nx;
                if (status[n] != gasp_pkg::ST_NEW || blk_map[n]) continue;
                if (nx == gx && ny == gy) begin
                    stack_path(cur, sx, sy);
                    return 1'b1;
                end
                came_dir[n] = d[1:0];
                g_cost[n] = g_cost[cur] + 1;
                f_cost[n] = g_cost[n] + absd(nx, gx) + absd(ny, gy);
                status[n] = gasp_pkg::ST_OPEN;
                open_q[open_n++] = n;
            end
        end
        return 1'b0;
    endfunction

    // Advance the shadow state by one command and queue the result it causes.
    function automatic void predict_move(logic [1:0] op, int x, int y, bit b, int gx, int gy);
        move_rsp_t r;
        r = '0;
        case (op)
            gasp_pkg::OP_WRITE:  blk_map[y * W + x] = b;
            gasp_pkg::OP_SEARCH: r.found = astar(x, y, gx, gy);
            gasp_pkg::OP_POP: begin
                if (move_n > 0) begin
                    move_n--;
                    r.dir = moves[move_n];
                    r.fp = 1'b1;
                end else begin
                    lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
                    case (lfsr[1:0])
                        2'd0:    r.dir = gasp_pkg::DIR_LEFT;
                        2'd1:    r.dir = gasp_pkg::DIR_UP;
                        2'd2:    r.dir = gasp_pkg::DIR_DOWN;
                        default: r.dir = gasp_pkg::DIR_RIGHT;
                    endcase
                end
            end
            default: ;
        endcase
        r.plen = move_n[10:0];
        pending = {pending, r};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Send one command beat; keep tvalid high across back-to-back beats.
    task automatic send_cmd(logic [1:0] op, int x, int y, bit b, int gx, int gy);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b0, gy[4:0], gx[4:0], b, y[4:0], x[4:0]};
        do @(posedge aclk); while (!s_axis_tready);
        predict_move(op, x, y, b, gx, gy);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_cmd(OP_UNUSED, 31, 31, 1, 31, 31);               // unused opcode: only a result beat
        send_cmd(gasp_pkg::OP_POP, 0, 0, 0, 0, 0);            // empty stack: random move
        send_cmd(gasp_pkg::OP_WRITE, 0, 0, 1, 0, 0);          // block corners
        send_cmd(gasp_pkg::OP_WRITE, 31, 31, 1, 0, 0);
        send_cmd(gasp_pkg::OP_SEARCH, 0, 0, 0, 31, 31);       // goal blocked: open list drains
        send_cmd(gasp_pkg::OP_WRITE, 31, 31, 0, 0, 0);
        send_cmd(gasp_pkg::OP_SEARCH, 0, 0, 0, 31, 31);       // blocked start is still searched
        repeat (4) send_cmd(gasp_pkg::OP_POP, 0, 0, 0, 0, 0);
        send_cmd(gasp_pkg::OP_WRITE, 0, 0, 0, 0, 0);
        send_cmd(gasp_pkg::OP_SEARCH, 5, 5, 0, 5, 5);         // start equals goal
        send_cmd(gasp_pkg::OP_POP, 0, 0, 0, 0, 0);
        send_cmd(gasp_pkg::OP_SEARCH, 10, 10, 0, 11, 10);     // goal next to start: empty path
        send_cmd(gasp_pkg::OP_POP, 0, 0, 0, 0, 0);
        send_cmd(gasp_pkg::OP_WRITE, 16, 15, 1, 0, 0);        // wall forces a detour
        send_cmd(gasp_pkg::OP_WRITE, 16, 16, 1, 0, 0);
        send_cmd(gasp_pkg::OP_WRITE, 16, 17, 1, 0, 0);
        send_cmd(gasp_pkg::OP_SEARCH, 14, 16, 0, 18, 16);
        repeat (3) send_cmd(gasp_pkg::OP_POP, 0, 0, 0, 0, 0);
        send_cmd(gasp_pkg::OP_SEARCH, 31, 31, 0, 0, 0);       // long path, leave it stacked
        drain();
    endtask

    // Mostly well-formed work: sparse obstacles, searches and pops in random order, with noise.
    task automatic test_random(int items, int idle, int stall);
        int pick;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_cmd(gasp_pkg::OP_WRITE, $urandom_range(31), $urandom_range(31),
                         $urandom_range(99) < 35, $urandom_range(31), $urandom_range(31));
            else if (pick < 45)
                send_cmd(gasp_pkg::OP_SEARCH, $urandom_range(31), $urandom_range(31),
                         $urandom_range(1), $urandom_range(31), $urandom_range(31));
            else if (pick < 95)
                send_cmd(gasp_pkg::OP_POP, $urandom_range(31), $urandom_range(31),
                         $urandom_range(1), $urandom_range(31), $urandom_range(31));
            else
                send_cmd(OP_UNUSED, $urandom_range(31), $urandom_range(31), $urandom_range(1),
                         $urandom_range(31), $urandom_range(31));
        end
        drain();
    endtask

    // Hold the result side off so the output register fills and input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_start = 1'b1;
        repeat (12) send_cmd(gasp_pkg::OP_POP, 0, 0, 0, 0, 0);
        drain();
    endtask

    initial begin
        lfsr = gasp_pkg::LFSR_SEED;
        move_n = 0;
        open_n = 0;
        for (int i = 0; i < N; i++) blk_map[i] = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(26, 0, 0);
        test_random(26, 63, 0);
        test_random(26, 0, 63);
        test_random(26, 11, 11);
        test_backpressure();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Long receiver hold: count the stretch down once it is requested.
    always @(posedge aclk) begin
        if (hold_start && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result side: check each beat against the oldest prediction, then pick tready.
    always @(posedge aclk) begin
        move_rsp_t want, got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[14:0];
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat", int'(got), 0);
            end else begin
                want = pending.pop_front();
                if (got.found !== want.found) report_mismatch("found", got.found, want.found);
                if (got.dir !== want.dir) report_mismatch("move_dir", got.dir, want.dir);
                if (got.fp !== want.fp) report_mismatch("from_path", got.fp, want.fp);
                if (got.plen !== want.plen) report_mismatch("path_length", got.plen, want.plen);
                if (m_axis_tdata[15] !== 1'b0) report_mismatch("pad bit", m_axis_tdata[15], 0);
            end
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
